FILE: rtl/core/antialiased_line_rasterizer_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the antialiased line rasterizer
// These macros wrap concurrent assertions clocked on clk with reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef ANTIALIASED_LINE_RASTERIZER_TOP_MACROS_SVH
`define ANTIALIASED_LINE_RASTERIZER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALR_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALR_ASSERT_NXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/core/alr_pkg.sv
// ----------------------------------------------------------------------------
// alr_pkg
// Types, constants and a helper function shared by the line rasterizer.
// ----------------------------------------------------------------------------
package alr_pkg;

    // Tile and number formats.
    localparam int TILE_SIZE     = 64;
    localparam int COORD_W       = 6;
    localparam int PIX_W         = 7;
    localparam int FRACTION_BITS = 16;
    localparam int COVER_FRAC    = 8;
    localparam int COVER_W       = 9;
    localparam int COVER_HALF    = 128;
    localparam int COVER_FULL    = 256;

    // Gradient magnitude reaches 1.0, so it needs one integer bit and a sign.
    localparam int GRAD_W = FRACTION_BITS + 2;
    // Line position: integer coordinate, fraction, headroom and sign.
    localparam int POS_W  = COORD_W + FRACTION_BITS + 2;
    // Gradient divider: one numerator bit per step.
    localparam int NUM_W     = COORD_W + FRACTION_BITS;
    localparam int QUOT_W    = FRACTION_BITS + 1;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
    } line_t;

    typedef struct packed {
        logic [PIX_W-1:0]   first_x;
        logic [PIX_W-1:0]   first_y;
        logic [PIX_W-1:0]   second_x;
        logic [PIX_W-1:0]   second_y;
        logic [COVER_W-1:0] first_cover;
        logic [COVER_W-1:0] second_cover;
        logic               last_column;
    } result_t;

    // A classified line, ordered along its major axis.
    typedef struct packed {
        logic               steep;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [GRAD_W-1:0]  grad;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIVIDE,
        FS_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_FIRST,
        BS_SPAN
    } back_state_t;

    // Clamp a coordinate to the tile.
    function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
        logic [COORD_W:0] wide;
        wide = {1'b0, v};
        if (wide >= (COORD_W + 1)'(TILE_SIZE))
        begin
            return COORD_W'(TILE_SIZE - 1);
        end
        return v;
    endfunction

endpackage

FILE: rtl/core/alr_front.sv
// ----------------------------------------------------------------------------
// alr_front
// Accepts a line, orders it along its major axis and divides out the
// gradient with a restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "antialiased_line_rasterizer_top_macros.svh"

module alr_front
    import alr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  line_t         line,
    output logic          busy,
    input  queue_status_t qstat,
    output logic          push,
    output cmd_t          push_cmd
);

    front_state_t state_reg;
    front_state_t state_next;

    cmd_t                 cmd_reg;
    logic                 neg_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [COORD_W-1:0]   dx_reg;
    logic [COORD_W-1:0]   rem_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic                 accept;
    logic                 div_last;

    // Classification of the incoming line.
    logic [COORD_W-1:0] ux0, uy0, ux1, uy1;
    logic [COORD_W-1:0] adx, ady;
    logic               steep;
    logic [COORD_W-1:0] m0, n0, m1, n1;
    logic               swap;
    cmd_t               cls_cmd;
    logic [COORD_W-1:0] cls_dx;
    logic               cls_neg;
    logic [COORD_W-1:0] cls_mag;

    always_comb
    begin
        ux0 = sat_coord(line.x_start);
        uy0 = sat_coord(line.y_start);
        ux1 = sat_coord(line.x_end);
        uy1 = sat_coord(line.y_end);
        adx = (ux1 >= ux0) ? (ux1 - ux0) : (ux0 - ux1);
        ady = (uy1 >= uy0) ? (uy1 - uy0) : (uy0 - uy1);
        steep = ady > adx;
        m0 = steep ? uy0 : ux0;
        n0 = steep ? ux0 : uy0;
        m1 = steep ? uy1 : ux1;
        n1 = steep ? ux1 : uy1;
        swap = m0 > m1;
        cls_cmd.steep = steep;
        cls_cmd.x0    = swap ? m1 : m0;
        cls_cmd.y0    = swap ? n1 : n0;
        cls_cmd.x1    = swap ? m0 : m1;
        cls_cmd.y1    = swap ? n0 : n1;
        cls_cmd.grad  = '0;
        cls_dx  = cls_cmd.x1 - cls_cmd.x0;
        cls_neg = cls_cmd.y1 < cls_cmd.y0;
        cls_mag = cls_neg ? (cls_cmd.y0 - cls_cmd.y1) : (cls_cmd.y1 - cls_cmd.y0);
    end

    // One restoring division step.
    logic [COORD_W:0]   rem_shift;
    logic               q_bit;
    logic [COORD_W-1:0] rem_new;

    always_comb
    begin
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        q_bit     = rem_shift >= {1'b0, dx_reg};
        rem_new   = q_bit ? COORD_W'(rem_shift - {1'b0, dx_reg}) : COORD_W'(rem_shift);
    end

    assign div_last = cnt_reg == CNT_W'(DIV_STEPS - 1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (start)
                begin
                    state_next = (cls_dx == '0) ? FS_PUSH : FS_DIVIDE;
                end
            end
            FS_DIVIDE:
            begin
                if (div_last)
                begin
                    state_next = FS_PUSH;
                end
            end
            FS_PUSH:
            begin
                if (!qstat.full)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    // Outputs: the signed gradient is formed from the quotient as the command leaves.
    logic [GRAD_W-1:0] grad_mag;

    always_comb
    begin
        busy     = state_reg != FS_IDLE;
        accept   = (state_reg == FS_IDLE) && start;
        push     = (state_reg == FS_PUSH) && !qstat.full;
        grad_mag = {1'b0, quot_reg};
        push_cmd = cmd_reg;
        push_cmd.grad = neg_reg ? (~grad_mag + GRAD_W'(1)) : grad_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command and divider datapath.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cls_cmd;
            dx_reg  <= cls_dx;
            num_reg <= {cls_mag, FRACTION_BITS'(0)};
            rem_reg <= '0;
            cnt_reg <= '0;
            if (cls_dx == '0)
            begin
                neg_reg  <= 1'b0;
                quot_reg <= QUOT_W'(1) << FRACTION_BITS;
            end
            else
            begin
                neg_reg  <= cls_neg;
                quot_reg <= '0;
            end
        end
        else if (state_reg == FS_DIVIDE)
        begin
            rem_reg  <= rem_new;
            num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], q_bit};
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
    end

    // The remainder stays below the divisor during the division.
    `ALR_ASSERT_IMP(a_rem_below_dx, state_reg == FS_DIVIDE, rem_reg < dx_reg, "remainder reached divisor")
    // A line is never steeper than one pixel per column after classification.
    `ALR_ASSERT_IMP(a_grad_bound, state_reg == FS_PUSH, quot_reg <= (QUOT_W'(1) << FRACTION_BITS), "gradient above one")
    // A command that finds room in the queue frees the front on the next cycle.
    `ALR_ASSERT_NXT(a_push_frees, push, !busy, "front stayed busy after transfer")

endmodule

FILE: rtl/core/alr_queue.sv
// ----------------------------------------------------------------------------
// alr_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module alr_queue
    import alr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic          pop,
    output cmd_t          head,
    output queue_status_t qstat
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : (p + QPTR_W'(1));
    endfunction

    // Status and head of queue.
    always_comb
    begin
        qstat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
        qstat.empty = count_reg == '0;
        head        = slot_reg[rd_ptr_reg];
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/core/alr_back.sv
// ----------------------------------------------------------------------------
// alr_back
// Walks a classified line column by column and emits one pixel pair with
// coverage per column, one result per cycle.
// ----------------------------------------------------------------------------
`include "antialiased_line_rasterizer_top_macros.svh"

module alr_back
    import alr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t qstat,
    input  cmd_t          head,
    output logic          pop,
    output logic          strobe,
    output result_t       result
);

    back_state_t state_reg;
    back_state_t state_next;

    cmd_t                     cmd_reg;
    logic [PIX_W-1:0]         col_reg;
    logic [PIX_W-1:0]         col_next;
    logic signed [POS_W-1:0]  pos_reg;
    logic signed [POS_W-1:0]  pos_next;
    result_t                  result_reg;
    result_t                  result_next;
    logic                     strobe_reg;
    logic                     strobe_next;

    logic                     span_end;

    // Place major and minor coordinates on x and y.
    function automatic result_t build_result(
        input logic               steep,
        input logic [PIX_W-1:0]   major,
        input logic [PIX_W-1:0]   minor,
        input logic [COVER_W-1:0] cover1,
        input logic [COVER_W-1:0] cover2,
        input logic               last
    );
        result_t r;
        if (steep)
        begin
            r.first_x  = minor;
            r.first_y  = major;
            r.second_x = minor + PIX_W'(1);
            r.second_y = major;
        end
        else
        begin
            r.first_x  = major;
            r.first_y  = minor;
            r.second_x = major;
            r.second_y = minor + PIX_W'(1);
        end
        r.first_cover  = cover1;
        r.second_cover = cover2;
        r.last_column  = last;
        return r;
    endfunction

    assign span_end = col_reg >= {1'b0, cmd_reg.x1};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = BS_FIRST;
                end
            end
            BS_FIRST:
            begin
                state_next = BS_SPAN;
            end
            BS_SPAN:
            begin
                if (span_end)
                begin
                    state_next = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    // Interior column: clamp the position and split it into pixel and coverage.
    logic [POS_W-1:0]      pos_clamped;
    logic [PIX_W-1:0]      whole;
    logic [COVER_FRAC-1:0] frac;
    logic [POS_W-1:0]      grad_ext;

    always_comb
    begin
        pos_clamped = pos_reg[POS_W-1] ? '0 : pos_reg;
        whole       = pos_clamped[FRACTION_BITS +: PIX_W];
        frac        = pos_clamped[FRACTION_BITS-COVER_FRAC +: COVER_FRAC];
        grad_ext    = {{(POS_W - GRAD_W){cmd_reg.grad[GRAD_W-1]}}, cmd_reg.grad};
    end

    // Outputs and datapath next values.
    always_comb
    begin
        pop         = 1'b0;
        strobe_next = 1'b0;
        result_next = result_reg;
        col_next    = col_reg;
        pos_next    = pos_reg;
        case (state_reg)
            BS_IDLE:
            begin
                pop = !qstat.empty;
            end
            BS_FIRST:
            begin
                strobe_next = 1'b1;
                result_next = build_result(cmd_reg.steep, {1'b0, cmd_reg.x0},
                    {1'b0, cmd_reg.y0}, COVER_W'(COVER_HALF), '0, 1'b0);
                col_next = {1'b0, cmd_reg.x0} + PIX_W'(1);
                pos_next = $signed({{(POS_W - NUM_W){1'b0}}, cmd_reg.y0,
                    FRACTION_BITS'(0)} + grad_ext);
            end
            BS_SPAN:
            begin
                strobe_next = 1'b1;
                if (span_end)
                begin
                    result_next = build_result(cmd_reg.steep, {1'b0, cmd_reg.x1},
                        {1'b0, cmd_reg.y1}, COVER_W'(COVER_HALF), '0, 1'b1);
                end
                else
                begin
                    result_next = build_result(cmd_reg.steep, col_reg, whole,
                        COVER_W'(COVER_FULL) - {1'b0, frac}, {1'b0, frac}, 1'b0);
                    col_next = col_reg + PIX_W'(1);
                    pos_next = $signed(pos_reg + grad_ext);
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BS_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
        result_reg <= result_next;
        col_reg    <= col_next;
        pos_reg    <= pos_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    // The column walk never passes one beyond the far endpoint.
    `ALR_ASSERT_IMP(a_col_bound, state_reg == BS_SPAN, col_reg <= ({1'b0, cmd_reg.x1} + PIX_W'(1)), "column ran past line end")
    // Every working cycle produces a result on the next cycle.
    `ALR_ASSERT_NXT(a_emit, state_reg != BS_IDLE, strobe_reg, "missing result")
    // The far endpoint closes the line and carries the last-column mark.
    `ALR_ASSERT_NXT(a_last, (state_reg == BS_SPAN) && span_end, strobe_reg && result_reg.last_column && (state_reg == BS_IDLE), "line not closed")

endmodule

FILE: rtl/core/antialiased_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_top
// Antialiased line rasterizer: one line in, one pixel pair per column out.
// ----------------------------------------------------------------------------
// Usage:
//   A line transfer happens on a rising edge where start is high and busy is
//   low; line carries both endpoints inside the 64 x 64 tile.
//   Results come out one per cycle within a line, each valid for exactly
//   one cycle while strobe is high, from the lowest major-axis column to
//   the highest. The final result of a line has last_column set. A line
//   spanning dx columns gives dx + 1 results; a single-point line gives two.
//   Sequence: the front classifies the line and then runs a 22-step
//   restoring divider for the gradient, which it skips when the line is a
//   single point. The back loads a command from the queue and then emits
//   the results, one per column.
//   Front and back overlap through a two-entry command queue, so a steady
//   stream of lines runs at the pace of the slower of the two. busy stays
//   high after a transfer until the front has pushed the command into the
//   queue, also while it waits there for room.
//   Reset clears both state machines and empties the queue; no clearing pass
//   is needed. The receiver cannot stall the result stream.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer_top
    import alr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  line_t   line,
    output logic    busy,
    output logic    strobe,
    output result_t result
);

    queue_status_t qstat;
    logic          push;
    cmd_t          push_cmd;
    logic          pop;
    cmd_t          head;

    // Classification and gradient division.
    alr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .line     (line),
        .busy     (busy),
        .qstat    (qstat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Command queue between the two halves.
    alr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    // Column walk and result generation.
    alr_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qstat  (qstat),
        .head   (head),
        .pop    (pop),
        .strobe (strobe),
        .result (result)
    );

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for the antialiased line rasterizer
// Sends directed and random lines through the command interface, predicts
// every column result of each accepted line with a fixed-point model of
// Wu's algorithm, and compares the result stream field by field.
// ----------------------------------------------------------------------------
module testbench;
    import alr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One pending line and the idle cycles that come before it.
    typedef struct {
        line_t       ln;
        int unsigned gap;
    } line_job_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    line_t   line = '0;
    logic    busy;
    logic    strobe;
    result_t result;

    line_job_t   pending_lines[$];
    result_t     expected_pixels[$];
    int unsigned idle_cycles = 0;
    int unsigned failures = 0;
    int unsigned lines_sent = 0;
    int unsigned steep_lines = 0;
    int unsigned point_lines = 0;
    int unsigned pixels_checked = 0;

    antialiased_line_rasterizer_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .line   (line),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    // Clock generation.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Print one failure line and count it.
    task automatic report_failure(string msg);
        failures++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
        begin
            report_failure($sformatf("result %0d, %s: got %0d, expected %0d",
                                     pixels_checked, name, got, want));
        end
    endtask

    // Queue one expected pixel pair; major and minor are in line space.
    function automatic void add_pixel_pair(bit steep, int major, int minor,
                                           int cover_a, int cover_b, bit last);
        result_t r;
        r.first_x      = PIX_W'(steep ? minor : major);
        r.first_y      = PIX_W'(steep ? major : minor);
        r.second_x     = PIX_W'(steep ? minor + 1 : major);
        r.second_y     = PIX_W'(steep ? major : minor + 1);
        r.first_cover  = COVER_W'(cover_a);
        r.second_cover = COVER_W'(cover_b);
        r.last_column  = last;
        expected_pixels.push_back(r);
    endfunction

    // Walk one line the way Wu's algorithm does, in Q.16 fixed point.
    // Six-bit coordinates never reach the tile size, so no clamping is needed.
    function automatic void predict_line(line_t ln);
        int  x0, y0, x1, y1, swap, dx, dy, adx, ady, grad, pos, p, col, frac;
        bit  steep;
        x0 = ln.x_start;
        y0 = ln.y_start;
        x1 = ln.x_end;
        y1 = ln.y_end;
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        steep = ady > adx;
        if (steep)
        begin
            swap = x0; x0 = y0; y0 = swap;
            swap = x1; x1 = y1; y1 = swap;
        end
        if (x0 > x1)
        begin
            swap = x0; x0 = x1; x1 = swap;
            swap = y0; y0 = y1; y1 = swap;
        end
        dx = x1 - x0;
        dy = y1 - y0;

        // Gradient magnitude is truncated, then the sign of dy is applied.
        if (dx == 0)
        begin
            grad = 1 << FRACTION_BITS;
        end
        else
        begin
            grad = (((dy < 0) ? -dy : dy) << FRACTION_BITS) / dx;
            if (dy < 0)
            begin
                grad = -grad;
            end
        end

        if (steep)
        begin
            steep_lines++;
        end
        if (dx == 0)
        begin
            point_lines++;
        end

        add_pixel_pair(steep, x0, y0, COVER_HALF, 0, 1'b0);
        pos = (y0 << FRACTION_BITS) + grad;
        for (col = x0 + 1; col <= x1 - 1; col++)
        begin
            p = (pos < 0) ? 0 : pos;
            frac = (p & ((1 << FRACTION_BITS) - 1)) >> (FRACTION_BITS - COVER_FRAC);
            add_pixel_pair(steep, col, p >> FRACTION_BITS, COVER_FULL - frac, frac, 1'b0);
            pos += grad;
        end
        add_pixel_pair(steep, x1, y1, COVER_HALF, 0, 1'b1);
    endfunction

    function automatic line_t make_line(int xs, int ys, int xe, int ye);
        line_t ln;
        ln.x_start = COORD_W'(xs);
        ln.y_start = COORD_W'(ys);
        ln.x_end   = COORD_W'(xe);
        ln.y_end   = COORD_W'(ye);
        return ln;
    endfunction

    function automatic int clip_coord(int v);
        return (v < 0) ? 0 : ((v > TILE_SIZE - 1) ? TILE_SIZE - 1 : v);
    endfunction

    // Random line with a mix of shapes: short, axis-aligned, diagonal, single-point, uniform.
    function automatic line_t random_line();
        int xs, ys, d;
        xs = $urandom_range(0, TILE_SIZE - 1);
        ys = $urandom_range(0, TILE_SIZE - 1);
        d  = $urandom_range(0, TILE_SIZE - 1);
        case ($urandom_range(0, 9))
            0, 1: return make_line(xs, ys, clip_coord(xs + $urandom_range(0, 6) - 3),
                                   clip_coord(ys + $urandom_range(0, 6) - 3));
            2:    return $urandom_range(0, 1) ? make_line(xs, ys, d, ys)
                                              : make_line(xs, ys, xs, d);
            3:    return make_line(xs, ys, clip_coord(xs + d), clip_coord(ys - d));
            4:    return make_line(xs, ys, xs, ys);
            default: return make_line(xs, ys, $urandom_range(0, TILE_SIZE - 1),
                                      $urandom_range(0, TILE_SIZE - 1));
        endcase
    endfunction

    function automatic void queue_line(line_t ln, int unsigned gap);
        line_job_t job;
        job.ln  = ln;
        job.gap = gap;
        pending_lines.push_back(job);
    endfunction

    // Driver: present the next line once its idle gap has passed.
    always @(posedge clk or negedge rst_n)
    begin
        line_job_t job;
        if (!rst_n)
        begin
            start       <= 1'b0;
            line        <= '0;
            idle_cycles <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_line(line);
                lines_sent++;
            end
            if (!start || !busy)
            begin
                if (pending_lines.size() > 0 && idle_cycles >= pending_lines[0].gap)
                begin
                    job          = pending_lines.pop_front();
                    line        <= job.ln;
                    start       <= 1'b1;
                    idle_cycles <= 0;
                end
                else
                begin
                    // Keep the payload moving while idle to catch stray captures.
                    line        <= line_t'($urandom);
                    start       <= 1'b0;
                    idle_cycles <= idle_cycles + 1;
                end
            end
        end
    end

    // Monitor: every strobed result must match the oldest expected pair.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && strobe)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_failure("result strobed with no result expected");
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("first_x", result.first_x, want.first_x);
                check_field("first_y", result.first_y, want.first_y);
                check_field("second_x", result.second_x, want.second_x);
                check_field("second_y", result.second_y, want.second_y);
                check_field("first_cover", result.first_cover, want.first_cover);
                check_field("second_cover", result.second_cover, want.second_cover);
                check_field("last_column", result.last_column, want.last_column);
                pixels_checked++;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int unsigned gap;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed lines: corners, axis-aligned, diagonals, single points,
        // steep and shallow lines in both directions, one-column spans.
        queue_line(make_line(0, 0, 0, 0), 0);
        queue_line(make_line(63, 63, 63, 63), 0);
        queue_line(make_line(0, 0, 63, 63), 3);
        queue_line(make_line(63, 0, 0, 63), 0);
        queue_line(make_line(0, 0, 63, 0), 0);
        queue_line(make_line(63, 5, 0, 5), 7);
        queue_line(make_line(0, 0, 0, 63), 0);
        queue_line(make_line(5, 63, 5, 0), 0);
        queue_line(make_line(0, 0, 63, 1), 11);
        queue_line(make_line(0, 63, 63, 62), 0);
        queue_line(make_line(0, 0, 1, 63), 0);
        queue_line(make_line(62, 63, 63, 0), 2);
        queue_line(make_line(10, 10, 11, 10), 0);
        queue_line(make_line(10, 10, 11, 11), 0);
        queue_line(make_line(10, 10, 12, 11), 0);
        queue_line(make_line(40, 20, 7, 33), 5);
        queue_line(make_line(21, 42, 0, 0), 0);
        queue_line(make_line(0, 63, 63, 0), 0);
        queue_line(make_line(63, 63, 0, 0), 1);
        queue_line(make_line(31, 32, 32, 31), 0);
        queue_line(make_line(0, 0, 63, 62), 0);
        queue_line(make_line(0, 0, 62, 63), 0);

        // Random lines; every third stretch of 25 lines runs back to back.
        for (int k = 0; k < 250; k++)
        begin
            gap = ((k / 25) % 3 == 1) ? 0 : $urandom_range(0, 11);
            queue_line(random_line(), gap);
        end

        while (pending_lines.size() > 0 || start || expected_pixels.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (80) @(posedge clk);
        if (expected_pixels.size() > 0)
        begin
            report_failure($sformatf("%0d results never arrived", expected_pixels.size()));
        end

        $display("Sent %0d lines (%0d steep, %0d single-point), checked %0d results.",
                 lines_sent, steep_lines, point_lines, pixels_checked);
        if (failures == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog for a hung block.
    initial
    begin
        #2ms;
        $display("Timeout: stimulus or results stalled.");
        $display("Test completed with failures");
        $finish;
    end

endmodule
